// ===== hdl/pns_pkg.sv =====
package pns_pkg;

   localparam int POS_W       = 12;
   localparam int GRAD_W      = 16;
   localparam int ENTRY_W     = 2 * GRAD_W;
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = 8;
   localparam int NOISE_W     = 16;
   localparam int IDX_W       = 24;
   localparam int NUM_CORNERS = 4;

   localparam int Q16_SHIFT  = 16;
   localparam int HALF_Q16   = 32768;
   localparam int ONE_Q16    = 65536;
   localparam int FADE_W     = 17;
   localparam int FRAC_EXT_W = 16;

   localparam int FADE_K6  = 6;
   localparam int FADE_K15 = 15 * 65536;
   localparam int FADE_K10 = 10;

   localparam int NOISE_MAX = 32767;
   localparam int NOISE_MIN = -32768;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

endpackage

// ===== hdl/pns_fade.sv =====
module pns_fade #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                         clock,
   input  logic [3:0]                   stage_en,
   input  logic [FRACTION_BITS-1:0]     frac,
   output logic [pns_pkg::FADE_W-1:0]   weight
);
   import pns_pkg::*;

   localparam int U_W   = 16;
   localparam int P_W   = 21;
   localparam int UP_W  = U_W + 1 + P_W;
   localparam int UU_W  = 2 * U_W;
   localparam int R_W   = 20;
   localparam int FM_W  = U_W + R_W + 1;
   localparam int FS_W  = FM_W - Q16_SHIFT;
   localparam longint TenQ32 = longint'(FADE_K10) << 32;

   logic [U_W-1:0]          u_in;
   logic signed [P_W-1:0]   p_in;
   logic signed [UP_W-1:0]  up_in, up_ff;
   logic [UU_W-1:0]         uu_in, uu_ff;
   logic [U_W-1:0]          u_ff2, u_ff3;
   logic signed [UP_W-1:0]  q_in;
   logic [R_W-1:0]          r_ff3, r_ff4;
   logic [U_W-1:0]          t2_in, t2_ff;
   logic [UU_W-1:0]         t3m_in;
   logic [U_W-1:0]          t3_ff;
   logic [FM_W-1:0]         fm_in;
   logic [FS_W-1:0]         fs_in;
   logic [FADE_W-1:0]       weight_in, weight_ff;

   always_comb begin
      u_in   = U_W'(32'(frac) << (U_W - FRACTION_BITS));
      p_in   = signed'(P_W'(u_in) * P_W'(FADE_K6)) - P_W'(FADE_K15);
      up_in  = UP_W'(signed'({1'b0, u_in})) * UP_W'(p_in);
      uu_in  = UU_W'(u_in) * UU_W'(u_in);
      q_in   = up_ff + UP_W'(TenQ32) + UP_W'(HALF_Q16);
      t2_in  = U_W'((uu_ff + UU_W'(HALF_Q16)) >> Q16_SHIFT);
      t3m_in = UU_W'(t2_ff) * UU_W'(u_ff3) + UU_W'(HALF_Q16);
      fm_in  = FM_W'(t3_ff) * FM_W'(r_ff4) + FM_W'(HALF_Q16);
      fs_in  = fm_in[FM_W-1:Q16_SHIFT];
      if (fs_in > FS_W'(ONE_Q16)) begin
         weight_in = FADE_W'(ONE_Q16);
      end else begin
         weight_in = FADE_W'(fs_in);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         up_ff <= up_in;
         uu_ff <= uu_in;
         u_ff2 <= u_in;
      end
      if (stage_en[1]) begin
         r_ff3 <= q_in[Q16_SHIFT +: R_W];
         t2_ff <= t2_in;
         u_ff3 <= u_ff2;
      end
      if (stage_en[2]) begin
         t3_ff <= t3m_in[UU_W-1:Q16_SHIFT];
         r_ff4 <= r_ff3;
      end
      if (stage_en[3]) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

// ===== hdl/perlin_noise_2d_sampler_top.sv =====
// Channel  Dir  Handshake              Fields
// req      in   req_valid, req_ready   kind, node_index, grad_x, grad_y, pos_x, pos_y
// rsp      out  rsp_valid, rsp_ready   noise_value, outside_grid
//
// One beat is accepted per cycle unless a stall on rsp backs up to req_ready.
// A sample result's latency is set by the quintic fade chain and the two serial blend multiplies.
// A load beat writes all four copies of the gradient table and gives no result.
// Reset clears only the stage valid bits; table entries are undefined until loaded.
// A stall on rsp holds each full stage with no empty stage after it, while empty stages keep filling.
module perlin_noise_2d_sampler_top #(
   parameter int GRID_SIZE     = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [pns_pkg::ADDR_W-1:0]           req_node_index,
   input  logic signed [pns_pkg::GRAD_W-1:0]    req_grad_x,
   input  logic signed [pns_pkg::GRAD_W-1:0]    req_grad_y,
   input  logic [pns_pkg::POS_W-1:0]            req_pos_x,
   input  logic [pns_pkg::POS_W-1:0]            req_pos_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pns_pkg::NOISE_W-1:0]   rsp_noise_value,
   output logic                                 rsp_outside_grid
);
   import pns_pkg::*;

   localparam int NUM_STAGES = 10;
   localparam int CELL_W     = POS_W + 1;
   localparam int DX_W       = FRACTION_BITS + 1;
   localparam int PROD_W     = GRAD_W + DX_W;
   localparam int DOT_W      = PROD_W + 1;
   localparam int DIFF_W     = DOT_W + 1;
   localparam int BLEND_W    = DIFF_W + FADE_W + 1;
   localparam int VAL_W      = DOT_W + 1;
   localparam int FRAC_HALF  = 1 << (FRACTION_BITS - 1);

   logic [NUM_STAGES:1]    vld_ff, vld_in;
   logic [NUM_STAGES+1:1]  stage_rdy;
   logic                   load_we;

   logic [POS_W-1:0]       cell_x, cell_y;
   logic [CELL_W-1:0]      cell_x_up, cell_y_up;
   logic [IDX_W-1:0]       base_idx, upper_idx;
   logic                   outside_in;
   logic [FRAC_EXT_W-1:0]  pos_ext_x, pos_ext_y;
   logic [ADDR_W-1:0]      rd_addr_in [NUM_CORNERS];
   logic [ENTRY_W-1:0]     rd_data_ff [NUM_CORNERS];

   logic [FRACTION_BITS-1:0] frac_x_ff1, frac_y_ff1;
   logic [NUM_STAGES:1]      out_ff;

   logic signed [DX_W-1:0]   dx_in [NUM_CORNERS];
   logic signed [DX_W-1:0]   dy_in [NUM_CORNERS];
   logic signed [PROD_W-1:0] prod_x_in [NUM_CORNERS];
   logic signed [PROD_W-1:0] prod_y_in [NUM_CORNERS];
   logic signed [PROD_W-1:0] prod_x_ff2 [NUM_CORNERS];
   logic signed [PROD_W-1:0] prod_y_ff2 [NUM_CORNERS];
   logic signed [DOT_W-1:0]  dot_in [NUM_CORNERS];
   logic signed [DOT_W-1:0]  dot_ff3 [NUM_CORNERS];
   logic signed [DOT_W-1:0]  dot_ff4 [NUM_CORNERS];
   logic signed [DOT_W-1:0]  dot_ff5 [NUM_CORNERS];

   logic [FADE_W-1:0]        weight_x, weight_y;
   logic [FADE_W-1:0]        wy_ff6, wy_ff7;
   logic signed [FADE_W:0]   wx_s, wy_s;
   logic signed [DIFF_W-1:0] diff_lo_in, diff_hi_in, diff_y_in;
   logic signed [BLEND_W-1:0] blend_lo_in, blend_hi_in, blend_y_in;
   logic signed [BLEND_W-1:0] blend_lo_ff6, blend_hi_ff6, blend_y_ff8;
   logic signed [BLEND_W-1:0] rnd_lo_in, rnd_hi_in, rnd_y_in;
   logic signed [DOT_W-1:0]  base_lo_ff6, base_hi_ff6;
   logic signed [DOT_W-1:0]  i0_in, i1_in, i0_ff7, i1_ff7, i0_ff8;
   logic signed [DOT_W-1:0]  v_in, v_ff9;
   logic signed [VAL_W-1:0]  v_rnd, v_shift;
   logic signed [NOISE_W-1:0] noise_in, noise_ff10;

   assign stage_rdy[NUM_STAGES+1] = rsp_ready;
   for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_ready
      assign stage_rdy[k] = !vld_ff[k] || stage_rdy[k+1];
   end

   assign req_ready = stage_rdy[1];
   assign load_we   = req_valid && req_ready && (req_kind == KIND_LOAD);
   assign vld_in    = {vld_ff[NUM_STAGES-1:1], req_valid && (req_kind == KIND_SAMPLE)};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_comb begin
      cell_x    = req_pos_x >> FRACTION_BITS;
      cell_y    = req_pos_y >> FRACTION_BITS;
      cell_x_up = CELL_W'(cell_x) + CELL_W'(1);
      cell_y_up = CELL_W'(cell_y) + CELL_W'(1);
      base_idx  = IDX_W'(GRID_SIZE) * IDX_W'(cell_y) + IDX_W'(cell_x);
      upper_idx = base_idx + IDX_W'(GRID_SIZE) + IDX_W'(1);
      outside_in = (cell_x_up >= CELL_W'(GRID_SIZE)) ||
                   (cell_y_up >= CELL_W'(GRID_SIZE)) ||
                   (upper_idx >= IDX_W'(TABLE_DEPTH));
      rd_addr_in[0] = base_idx[ADDR_W-1:0];
      rd_addr_in[1] = ADDR_W'(base_idx + IDX_W'(1));
      rd_addr_in[2] = ADDR_W'(base_idx + IDX_W'(GRID_SIZE));
      rd_addr_in[3] = upper_idx[ADDR_W-1:0];
      pos_ext_x = FRAC_EXT_W'(req_pos_x);
      pos_ext_y = FRAC_EXT_W'(req_pos_y);
   end

   // Each corner reads its own copy of the table, so all four reads happen in the same cycle.
   for (genvar b = 0; b < NUM_CORNERS; b++) begin : g_bank
      logic [ENTRY_W-1:0] bank_mem [TABLE_DEPTH];
      always_ff @(posedge clock) begin
         if (load_we) begin
            bank_mem[req_node_index] <= {req_grad_y, req_grad_x};
         end
         if (stage_rdy[1]) begin
            rd_data_ff[b] <= bank_mem[rd_addr_in[b]];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         dx_in[k] = k[0] ? signed'({1'b1, frac_x_ff1}) : signed'({1'b0, frac_x_ff1});
         dy_in[k] = k[1] ? signed'({1'b1, frac_y_ff1}) : signed'({1'b0, frac_y_ff1});
         prod_x_in[k] = PROD_W'(signed'(rd_data_ff[k][GRAD_W-1:0])) *
                        PROD_W'(dx_in[k]);
         prod_y_in[k] = PROD_W'(signed'(rd_data_ff[k][ENTRY_W-1:GRAD_W])) *
                        PROD_W'(dy_in[k]);
         dot_in[k] = DOT_W'(prod_x_ff2[k]) + DOT_W'(prod_y_ff2[k]);
      end
   end

   pns_fade #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_fade_x (
      .clock    (clock),
      .stage_en (stage_rdy[5:2]),
      .frac     (frac_x_ff1),
      .weight   (weight_x)
   );

   pns_fade #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_fade_y (
      .clock    (clock),
      .stage_en (stage_rdy[5:2]),
      .frac     (frac_y_ff1),
      .weight   (weight_y)
   );

   always_comb begin
      wx_s        = signed'({1'b0, weight_x});
      wy_s        = signed'({1'b0, wy_ff7});
      diff_lo_in  = DIFF_W'(dot_ff5[1]) - DIFF_W'(dot_ff5[0]);
      diff_hi_in  = DIFF_W'(dot_ff5[3]) - DIFF_W'(dot_ff5[2]);
      blend_lo_in = BLEND_W'(diff_lo_in) * BLEND_W'(wx_s);
      blend_hi_in = BLEND_W'(diff_hi_in) * BLEND_W'(wx_s);
      rnd_lo_in   = (blend_lo_ff6 + BLEND_W'(HALF_Q16)) >>> Q16_SHIFT;
      rnd_hi_in   = (blend_hi_ff6 + BLEND_W'(HALF_Q16)) >>> Q16_SHIFT;
      i0_in       = base_lo_ff6 + DOT_W'(rnd_lo_in);
      i1_in       = base_hi_ff6 + DOT_W'(rnd_hi_in);
      diff_y_in   = DIFF_W'(i1_ff7) - DIFF_W'(i0_ff7);
      blend_y_in  = BLEND_W'(diff_y_in) * BLEND_W'(wy_s);
      rnd_y_in    = (blend_y_ff8 + BLEND_W'(HALF_Q16)) >>> Q16_SHIFT;
      v_in        = i0_ff8 + DOT_W'(rnd_y_in);
      v_rnd       = VAL_W'(v_ff9) + VAL_W'(FRAC_HALF);
      v_shift     = v_rnd >>> FRACTION_BITS;
      if (out_ff[NUM_STAGES-1]) begin
         noise_in = '0;
      end else if (v_shift > VAL_W'(NOISE_MAX)) begin
         noise_in = NOISE_W'(NOISE_MAX);
      end else if (v_shift < VAL_W'(NOISE_MIN)) begin
         noise_in = NOISE_W'(NOISE_MIN);
      end else begin
         noise_in = NOISE_W'(v_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         frac_x_ff1 <= pos_ext_x[FRACTION_BITS-1:0];
         frac_y_ff1 <= pos_ext_y[FRACTION_BITS-1:0];
         out_ff[1]  <= outside_in;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (stage_rdy[k]) begin
            out_ff[k] <= out_ff[k-1];
         end
      end
      if (stage_rdy[2]) begin
         prod_x_ff2 <= prod_x_in;
         prod_y_ff2 <= prod_y_in;
      end
      if (stage_rdy[3]) begin
         dot_ff3 <= dot_in;
      end
      if (stage_rdy[4]) begin
         dot_ff4 <= dot_ff3;
      end
      if (stage_rdy[5]) begin
         dot_ff5 <= dot_ff4;
      end
      if (stage_rdy[6]) begin
         blend_lo_ff6 <= blend_lo_in;
         blend_hi_ff6 <= blend_hi_in;
         base_lo_ff6  <= dot_ff5[0];
         base_hi_ff6  <= dot_ff5[2];
         wy_ff6       <= weight_y;
      end
      if (stage_rdy[7]) begin
         i0_ff7 <= i0_in;
         i1_ff7 <= i1_in;
         wy_ff7 <= wy_ff6;
      end
      if (stage_rdy[8]) begin
         blend_y_ff8 <= blend_y_in;
         i0_ff8      <= i0_ff7;
      end
      if (stage_rdy[9]) begin
         v_ff9 <= v_in;
      end
      if (stage_rdy[10]) begin
         noise_ff10 <= noise_in;
      end
   end

   assign rsp_valid        = vld_ff[NUM_STAGES];
   assign rsp_noise_value  = noise_ff10;
   assign rsp_outside_grid = out_ff[NUM_STAGES];

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_LOAD)) |=> !vld_ff[1])
      else $error("load beat entered the sample pipeline");

   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_SAMPLE)) |=> vld_ff[1])
      else $error("accepted sample beat was lost at pipeline entry");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outside_grid) |-> (rsp_noise_value == '0))
      else $error("off-grid result carries a nonzero noise value");

   a_mid_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[6] && !stage_rdy[7]) |=> (vld_ff[6] && $stable(blend_lo_ff6)))
      else $error("stalled blend stage changed or lost its beat");

endmodule

// ===== tb/perlin_noise_checker.sv =====
`timescale 1ns / 1ps

module perlin_noise_checker #(
   parameter int GRID_SIZE     = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [pns_pkg::ADDR_W-1:0]           req_node_index,
   input  logic signed [pns_pkg::GRAD_W-1:0]    req_grad_x,
   input  logic signed [pns_pkg::GRAD_W-1:0]    req_grad_y,
   input  logic [pns_pkg::POS_W-1:0]            req_pos_x,
   input  logic [pns_pkg::POS_W-1:0]            req_pos_y,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [pns_pkg::NOISE_W-1:0]   rsp_noise_value,
   input  logic                                 rsp_outside_grid,
   output int                                   failures,
   output int                                   outstanding
);
   import pns_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise;
      logic                      outside;
   } noise_result_type;

   logic [ENTRY_W-1:0] grad_table [TABLE_DEPTH];
   noise_result_type   expected_noise [$];
   int                 mismatch_count = 0;

   assign failures = mismatch_count;

   initial begin
      outstanding = 0;
      foreach (grad_table[i]) grad_table[i] = '0;
   end

   function automatic longint fade_weight(input longint frac);
      longint u, p, q, r, t2, t3, f;
      u  = frac <<< (FRAC_EXT_W - FRACTION_BITS);
      p  = FADE_K6 * u - FADE_K15;
      q  = u * p + (longint'(FADE_K10) <<< (2 * Q16_SHIFT));
      r  = (q + HALF_Q16) >>> Q16_SHIFT;
      t2 = (u * u + HALF_Q16) >>> Q16_SHIFT;
      t3 = (t2 * u + HALF_Q16) >>> Q16_SHIFT;
      f  = (t3 * r + HALF_Q16) >>> Q16_SHIFT;
      if (f > ONE_Q16) f = ONE_Q16;
      if (f < 0) f = 0;
      return f;
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint w);
      return (a * (ONE_Q16 - w) + b * w + HALF_Q16) >>> Q16_SHIFT;
   endfunction

   function automatic longint corner_dot(input int cx, input int cy,
                                         input longint dx, input longint dy);
      logic [ENTRY_W-1:0]       entry;
      logic signed [GRAD_W-1:0] gx, gy;
      entry = grad_table[(GRID_SIZE * cy + cx) % TABLE_DEPTH];
      gx = entry[GRAD_W-1:0];
      gy = entry[ENTRY_W-1:GRAD_W];
      return gx * dx + gy * dy;
   endfunction

   function automatic noise_result_type predict_noise(input logic [POS_W-1:0] px,
                                                      input logic [POS_W-1:0] py);
      noise_result_type res;
      int               cx, cy, upper;
      longint           fx, fy, one, d0, d1, d2, d3, wx, wy, i0, i1, v;
      cx    = int'(px >> FRACTION_BITS);
      cy    = int'(py >> FRACTION_BITS);
      upper = GRID_SIZE * (cy + 1) + cx + 1;
      res.noise   = '0;
      res.outside = 1'b1;
      if (cx + 1 >= GRID_SIZE || cy + 1 >= GRID_SIZE || upper >= TABLE_DEPTH) begin
         return res;
      end
      one = longint'(1) <<< FRACTION_BITS;
      fx  = px % one;
      fy  = py % one;
      d0  = corner_dot(cx, cy, fx, fy);
      d1  = corner_dot(cx + 1, cy, fx - one, fy);
      d2  = corner_dot(cx, cy + 1, fx, fy - one);
      d3  = corner_dot(cx + 1, cy + 1, fx - one, fy - one);
      wx  = fade_weight(fx);
      wy  = fade_weight(fy);
      i0  = mix(d0, d1, wx);
      i1  = mix(d2, d3, wx);
      v   = (mix(i0, i1, wy) + (one >>> 1)) >>> FRACTION_BITS;
      if (v > NOISE_MAX) v = NOISE_MAX;
      if (v < NOISE_MIN) v = NOISE_MIN;
      res.noise   = NOISE_W'(v);
      res.outside = 1'b0;
      return res;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      noise_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_noise.size() == 0) begin
               report_failure($sformatf("result beat with nothing expected: noise %0d flag %0b",
                                        rsp_noise_value, rsp_outside_grid));
            end else begin
               want = expected_noise.pop_front();
               if (rsp_noise_value !== want.noise) begin
                  report_failure($sformatf("noise_value expected %0d, got %0d",
                                           want.noise, rsp_noise_value));
               end
               if (rsp_outside_grid !== want.outside) begin
                  report_failure($sformatf("outside_grid expected %0b, got %0b",
                                           want.outside, rsp_outside_grid));
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               grad_table[req_node_index] = {req_grad_y, req_grad_x};
            end else begin
               expected_noise.push_back(predict_noise(req_pos_x, req_pos_y));
            end
         end
         outstanding <= expected_noise.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import pns_pkg::*;

   localparam int GRID_SIZE      = 16;
   localparam int FRACTION_BITS  = 8;
   localparam int FRAC_MAX       = (1 << FRACTION_BITS) - 1;
   localparam int GRAD_ONE       = 16384;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int HOLD_CYCLES    = 250;
   localparam int TAIL_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} ready_pattern_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = KIND_LOAD;
   logic [ADDR_W-1:0]           req_node_index = '0;
   logic signed [GRAD_W-1:0]    req_grad_x = '0;
   logic signed [GRAD_W-1:0]    req_grad_y = '0;
   logic [POS_W-1:0]            req_pos_x = '0;
   logic [POS_W-1:0]            req_pos_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [NOISE_W-1:0]   rsp_noise_value;
   logic                        rsp_outside_grid;

   int   failures;
   int   outstanding;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   gapless_left = 0;
   logic hold_request = 1'b0;
   bit   grad_written [TABLE_DEPTH];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   perlin_noise_2d_sampler_top #(
      .GRID_SIZE     (GRID_SIZE),
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_node_index   (req_node_index),
      .req_grad_x       (req_grad_x),
      .req_grad_y       (req_grad_y),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_noise_value  (rsp_noise_value),
      .rsp_outside_grid (rsp_outside_grid)
   );

   perlin_noise_checker #(
      .GRID_SIZE     (GRID_SIZE),
      .FRACTION_BITS (FRACTION_BITS)
   ) noise_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_node_index   (req_node_index),
      .req_grad_x       (req_grad_x),
      .req_grad_y       (req_grad_y),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_noise_value  (rsp_noise_value),
      .rsp_outside_grid (rsp_outside_grid),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("perlin_noise_2d_sampler_top verification failed");
         $finish;
      end
   end

   initial begin
      ready_pattern_type pattern;
      int                span, period;
      bit                hold_served;
      hold_served = 1'b0;
      forever begin
         pattern = ready_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(4, 64);
         period  = $urandom_range(2, 6);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            if (hold_request && !hold_served) begin
               hold_served = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               case (pattern)
                  RX_STEADY: rsp_ready <= 1'b1;
                  RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default:   rsp_ready <= (c % period == 0);
               endcase
            end
         end
      end
   end

   function automatic int node_of(input int cx, input int cy);
      return GRID_SIZE * cy + cx;
   endfunction

   function automatic logic [POS_W-1:0] pos_of(input int cell_num, input int frac);
      return POS_W'((cell_num << FRACTION_BITS) | frac);
   endfunction

   function automatic bit corners_loaded(input int cx, input int cy);
      return grad_written[node_of(cx, cy)] && grad_written[node_of(cx + 1, cy)] &&
             grad_written[node_of(cx, cy + 1)] && grad_written[node_of(cx + 1, cy + 1)];
   endfunction

   function automatic int rand_frac();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return FRAC_MAX;
         default: return $urandom_range(0, FRAC_MAX);
      endcase
   endfunction

   function automatic int rand_component();
      case ($urandom_range(0, 9))
         0:       return int'(signed'(GRAD_W'($urandom)));
         1:       return GRAD_ONE;
         2:       return -GRAD_ONE;
         default: return int'($urandom_range(0, 2 * GRAD_ONE)) - GRAD_ONE;
      endcase
   endfunction

   task automatic send_beat(input logic kind, input logic [ADDR_W-1:0] idx,
                            input logic signed [GRAD_W-1:0] gx,
                            input logic signed [GRAD_W-1:0] gy,
                            input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      int gap;
      if (burst_left == 0) begin
         if (gapless_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (gapless_left > 0) gapless_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_node_index <= idx;
      req_grad_x     <= gx;
      req_grad_y     <= gy;
      req_pos_x      <= px;
      req_pos_y      <= py;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_gradient(input int idx, input int gx, input int gy);
      grad_written[idx] = 1'b1;
      send_beat(KIND_LOAD, ADDR_W'(idx), GRAD_W'(gx), GRAD_W'(gy),
                POS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 4095)));
   endtask

   task automatic sample_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      send_beat(KIND_SAMPLE, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)),
                GRAD_W'(rand_component()), GRAD_W'(rand_component()), px, py);
   endtask

   task automatic random_sample();
      logic [POS_W-1:0] px, py;
      int               cx, cy;
      bit               found;
      found = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         px = POS_W'($urandom);
         py = POS_W'($urandom);
         cx = int'(px >> FRACTION_BITS);
         cy = int'(py >> FRACTION_BITS);
         if (cx + 1 < GRID_SIZE && cy + 1 < GRID_SIZE && !corners_loaded(cx, cy)) begin
            px = pos_of(GRID_SIZE - 1, rand_frac());
         end
      end else begin
         for (int tries = 0; tries < 16 && !found; tries++) begin
            cx = $urandom_range(0, GRID_SIZE - 2);
            cy = $urandom_range(0, GRID_SIZE - 2);
            found = corners_loaded(cx, cy);
         end
         if (!found) begin
            cx = 0;
            cy = 0;
         end
         px = pos_of(cx, rand_frac());
         py = pos_of(cy, rand_frac());
      end
      sample_at(px, py);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int last;
      last = GRID_SIZE - 2;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      load_gradient(node_of(0, 0), GRAD_ONE, -GRAD_ONE);
      load_gradient(node_of(1, 0), -GRAD_ONE, GRAD_ONE);
      load_gradient(node_of(0, 1), 32767, -32768);
      load_gradient(node_of(1, 1), -32768, 32767);
      sample_at(pos_of(0, 0), pos_of(0, 0));
      sample_at(pos_of(0, FRAC_MAX), pos_of(0, FRAC_MAX));
      sample_at(pos_of(0, (FRAC_MAX + 1) / 2), pos_of(0, (FRAC_MAX + 1) / 2));
      sample_at(pos_of(0, FRAC_MAX), pos_of(0, 0));
      load_gradient(node_of(last, last), 0, 0);
      load_gradient(node_of(last + 1, last), GRAD_ONE, GRAD_ONE);
      load_gradient(node_of(last, last + 1), -GRAD_ONE, -GRAD_ONE);
      load_gradient(node_of(last + 1, last + 1), 32767, 32767);
      sample_at(pos_of(last, 0), pos_of(last, 0));
      sample_at(pos_of(last, FRAC_MAX), pos_of(last, FRAC_MAX));
      sample_at(POS_W'(4095), POS_W'(4095));
      sample_at(pos_of(GRID_SIZE - 1, 0), pos_of(0, 0));
      sample_at(pos_of(0, 0), pos_of(GRID_SIZE - 1, 0));
      load_gradient(node_of(2, 2), 32767, 32767);
      load_gradient(node_of(3, 2), -32768, 32767);
      load_gradient(node_of(2, 3), 32767, -32768);
      load_gradient(node_of(3, 3), -32768, -32768);
      sample_at(pos_of(2, (FRAC_MAX + 1) / 2), pos_of(2, (FRAC_MAX + 1) / 2));
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            gapless_left = 80;
            hold_request <= 1'b1;
         end
         if (n == 2 * RANDOM_ITEMS / 3) drain_results();
         if ($urandom_range(0, 99) < ((n < 300) ? 60 : 30)) begin
            load_gradient($urandom_range(0, TABLE_DEPTH - 1), rand_component(),
                          rand_component());
         end else begin
            random_sample();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("perlin_noise_2d_sampler_top verification clean");
      end else begin
         $display("perlin_noise_2d_sampler_top verification failed");
      end
      $finish;
   end

endmodule
